// ----- sv/u64ht_pkg.sv -----
// Package for the 64-bit key hash table: shared types, codes and constants.
// Used by every module of the block but the RAM; depends on nothing.
package u64ht_pkg;

  localparam int MAX_BUCKETS_DEF = 4096;
  localparam int POOL_DEPTH_DEF  = 4096;

  // murmur3 fmix64 multipliers and shift
  localparam logic [63:0] MIX_C1    = 64'hFF51AFD7ED558CCD;
  localparam logic [63:0] MIX_C2    = 64'hC4CEB9FE1A85EC53;
  localparam int          MIX_SHIFT = 33;

  localparam logic [3:0]  MIN_LOG2  = 4'd3;
  localparam int          CNT_OUT_W = 13;
  localparam int          COLL_W    = 12;
  localparam logic [11:0] COLL_MAX  = 12'hFFF;

  typedef enum logic [1:0] {
    REQ_PUT    = 2'd0,
    REQ_GET    = 2'd1,
    REQ_REMOVE = 2'd2,
    REQ_NOP    = 2'd3
  } req_t;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_MISS = 2'd1,
    ST_FULL = 2'd2
  } status_t;

  // one classified request word passed from front to back
  typedef struct packed {
    req_t        req;
    logic [63:0] key;
    logic [63:0] value;
    logic [63:0] hash;
  } item_t;

endpackage

// ----- sv/u64_key_chained_hash_table_top.sv -----
// Hash table top: the front hashes one word at a time with fmix64 (two 64-bit multiplies
// done as three 32x32 partial products each on one shared multiplier).
// Back: one word at a time, with one node read per chain step; a growth walks every old
// bucket and every stored entry.
// Reset (sync, rst high) and every config write sweep all MAX_BUCKETS heads with full high.
module u64_key_chained_hash_table_top #(
  parameter int MAX_BUCKETS = u64ht_pkg::MAX_BUCKETS_DEF,
  parameter int POOL_DEPTH  = u64ht_pkg::POOL_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  // request side
  input  logic        push,
  output logic        full,
  input  logic [1:0]  req_type,
  input  logic [63:0] key,
  input  logic [63:0] value,
  // result side
  output logic        empty,
  input  logic        pop,
  output logic [1:0]  status,
  output logic [63:0] read_value,
  output logic [12:0] entry_count,
  output logic [12:0] bucket_total,
  output logic [11:0] collision_count,
  // configuration write channel
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [3:0]  initial_bucket_log2
);

  logic             front_busy;
  logic             clearing;
  logic             accept;
  logic             f_valid;
  u64ht_pkg::item_t f_item;
  logic             q_ready;
  logic             q_valid;
  logic             q_pop;
  u64ht_pkg::item_t q_item;
  logic             res_valid;

  // hold off new words while one is hashed or waits for the queue, or while the bucket sweep runs
  assign full      = front_busy || clearing;
  assign accept    = push && !full;
  // the register is taken at any time; a write restarts the clear sweep
  assign cfg_ready = 1'b1;
  assign empty     = !res_valid;

  u64ht_front u_front (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .req_type  (req_type),
    .key       (key),
    .value     (value),
    .busy      (front_busy),
    .out_valid (f_valid),
    .out_item  (f_item),
    .out_ready (q_ready)
  );

  // decouple hashing from the chain walk
  u64ht_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (f_valid),
    .in_ready  (q_ready),
    .in_item   (f_item),
    .out_valid (q_valid),
    .out_pop   (q_pop),
    .out_item  (q_item)
  );

  // table state and the result register, which lets the back move on
  // to the next word only once its result has a slot
  u64ht_back #(
    .MAX_BUCKETS (MAX_BUCKETS),
    .POOL_DEPTH  (POOL_DEPTH)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_valid && cfg_ready),
    .cfg_log2    (initial_bucket_log2),
    .q_valid     (q_valid),
    .q_item      (q_item),
    .q_pop       (q_pop),
    .clearing    (clearing),
    .pop         (pop),
    .res_valid   (res_valid),
    .res_status  (status),
    .res_value   (read_value),
    .res_entries (entry_count),
    .res_buckets (bucket_total),
    .res_coll    (collision_count)
  );

endmodule

// ----- sv/u64ht_ram.sv -----
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module u64ht_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- sv/u64ht_front.sv -----
// Front end: takes a request word and computes its fmix64 hash on one
// shared 32x32 multiplier. Depends on u64ht_pkg.
module u64ht_front (
  input  logic               clk,
  input  logic               rst,
  input  logic               accept,
  input  logic [1:0]         req_type,
  input  logic [63:0]        key,
  input  logic [63:0]        value,
  output logic               busy,
  output logic               out_valid,
  output u64ht_pkg::item_t   out_item,
  input  logic               out_ready
);

  typedef enum logic [1:0] {F_IDLE, F_MUL, F_HOLD} fstate_t;

  fstate_t     state;
  logic        second;
  logic [1:0]  step;
  logic [63:0] v;
  logic [63:0] acc;
  logic [63:0] prod;
  logic [1:0]  req_q;
  logic [63:0] key_q;
  logic [63:0] val_q;

  logic [63:0] mconst;
  logic [31:0] a_op;
  logic [31:0] b_op;
  logic [63:0] pp;
  logic [63:0] sum;

  always_comb begin
    mconst = second ? u64ht_pkg::MIX_C2 : u64ht_pkg::MIX_C1;
    unique case (step)
      2'd0: begin
        a_op = v[31:0];
        b_op = mconst[31:0];
      end
      2'd1: begin
        a_op = v[31:0];
        b_op = mconst[63:32];
      end
      default: begin
        a_op = v[63:32];
        b_op = mconst[31:0];
      end
    endcase
    pp  = a_op * b_op;
    sum = acc + {prod[31:0], 32'd0};
  end

  // step 0..2 issue partial products, steps 1..3 accumulate them
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
    end else begin
      unique case (state)
        F_IDLE: begin
          if (accept) begin
            req_q  <= req_type;
            key_q  <= key;
            val_q  <= value;
            v      <= key ^ (key >> u64ht_pkg::MIX_SHIFT);
            step   <= 2'd0;
            second <= 1'b0;
            state  <= F_MUL;
          end
        end
        F_MUL: begin
          if (step != 2'd3) begin
            prod <= pp;
          end
          if (step == 2'd1) begin
            acc <= prod;
          end else if (step == 2'd2) begin
            acc <= sum;
          end
          step <= step + 2'd1;
          if (step == 2'd3) begin
            v <= sum ^ (sum >> u64ht_pkg::MIX_SHIFT);
            if (second) begin
              state <= F_HOLD;
            end else begin
              second <= 1'b1;
            end
          end
        end
        F_HOLD: begin
          if (out_ready) begin
            state <= F_IDLE;
          end
        end
        default: state <= F_IDLE;
      endcase
    end
  end

  assign busy           = (state != F_IDLE);
  assign out_valid      = (state == F_HOLD);
  assign out_item.req   = u64ht_pkg::req_t'(req_q);
  assign out_item.key   = key_q;
  assign out_item.value = val_q;
  assign out_item.hash  = v;

endmodule

// ----- sv/u64ht_queue.sv -----
// Two-entry queue of hashed request words between front and back.
// Depends on u64ht_pkg.
module u64ht_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  u64ht_pkg::item_t in_item,
  output logic             out_valid,
  input  logic             out_pop,
  output u64ht_pkg::item_t out_item
);

  localparam int QD  = 2;
  localparam int QAW = $clog2(QD);

  u64ht_pkg::item_t     mem [QD];
  logic [QAW-1:0]       wp;
  logic [QAW-1:0]       rp;
  logic [$clog2(QD):0]  cnt;
  logic                 do_push;
  logic                 do_pop;

  assign in_ready  = (cnt != ($clog2(QD)+1)'(QD));
  assign out_valid = (cnt != '0);
  assign out_item  = mem[rp];
  assign do_push   = in_valid && in_ready;
  assign do_pop    = out_pop && out_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wp] <= in_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= '0;
      rp  <= '0;
      cnt <= '0;
    end else begin
      if (do_push) begin
        wp <= wp + 1'b1;
      end
      if (do_pop) begin
        rp <= rp + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt <= cnt + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt <= cnt - 1'b1;
      end
    end
  end

endmodule

// ----- sv/u64ht_back.sv -----
// Back end: bucket chains, node pool, growth and result register.
// Depends on u64ht_pkg and u64ht_ram.
module u64ht_back #(
  parameter int MAX_BUCKETS = u64ht_pkg::MAX_BUCKETS_DEF,
  parameter int POOL_DEPTH  = u64ht_pkg::POOL_DEPTH_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  logic [3:0]       cfg_log2,
  input  logic             q_valid,
  input  u64ht_pkg::item_t q_item,
  output logic             q_pop,
  output logic             clearing,
  input  logic             pop,
  output logic             res_valid,
  output logic [1:0]       res_status,
  output logic [63:0]      res_value,
  output logic [12:0]      res_entries,
  output logic [12:0]      res_buckets,
  output logic [11:0]      res_coll
);

  localparam int PW = $clog2(POOL_DEPTH);
  localparam int LW = PW + 1;
  localparam int BW = $clog2(MAX_BUCKETS);
  localparam int NB = BW + 1;
  localparam int EW = PW + 1;
  localparam int CW = ((EW > NB) ? EW : NB) + 2;
  localparam logic [LW-1:0] NIL = LW'(POOL_DEPTH);

  typedef enum logic [3:0] {
    B_CLEAR, B_IDLE, B_HEAD, B_WALK, B_REM, B_MISS, B_INS, B_INS2,
    B_GHEAD, B_GHEADW, B_GNODE, B_GWB, B_GWB2, B_RESP
  } bstate_t;

  function automatic logic [NB-1:0] start_buckets(input logic [3:0] lg);
    int l;
    l = (lg < u64ht_pkg::MIN_LOG2) ? int'(u64ht_pkg::MIN_LOG2) : int'(lg);
    if (l >= BW) begin
      return NB'(MAX_BUCKETS);
    end
    return NB'(1) << l;
  endfunction

  bstate_t            state;
  logic [BW-1:0]      clr;
  u64ht_pkg::item_t   cur;
  logic [BW-1:0]      cur_idx;
  logic [PW-1:0]      node;
  logic [LW-1:0]      prev;
  logic [LW-1:0]      free_head;
  logic [EW-1:0]      fresh;
  logic [EW-1:0]      entries;
  logic [NB-1:0]      buckets;
  logic [11:0]        coll;
  logic [BW-1:0]      gi;
  logic [LW-1:0]      lo;
  logic [LW-1:0]      hi;
  logic [EW-1:0]      gcnt;
  u64ht_pkg::status_t st;
  logic [63:0]        rd;

  // memory ports
  logic          head_we;
  logic [BW-1:0] head_waddr;
  logic [LW-1:0] head_wdata;
  logic [BW-1:0] head_raddr;
  logic [LW-1:0] head_rd;
  logic [PW-1:0] node_raddr;
  logic [PW-1:0] data_waddr;
  logic          key_we;
  logic          val_we;
  logic          hash_we;
  logic          link_we;
  logic [PW-1:0] link_waddr;
  logic [LW-1:0] link_wdata;
  logic [63:0]   key_rd;
  logic [63:0]   val_rd;
  logic [BW-1:0] hash_rd;
  logic [LW-1:0] link_rd;

  logic [BW-1:0] mask;
  logic [BW-1:0] q_idx;
  logic [BW-1:0] cur_hidx;
  logic          key_hit;
  logic          grow_need;
  logic          pool_full;
  logic          old_bit;
  logic [LW-1:0] gtarget;
  logic [PW-1:0] new_node;
  logic [11:0]   coll_inc;
  logic          res_load;

  always_comb begin
    mask      = BW'(buckets - NB'(1));
    q_idx     = q_item.hash[BW-1:0] & mask;
    cur_hidx  = cur.hash[BW-1:0] & mask;
    key_hit   = (key_rd == cur.key);
    grow_need = (CW'({entries, 2'b00}) > (CW'(buckets) + CW'({buckets, 1'b0})))
                && (buckets < NB'(MAX_BUCKETS));
    pool_full = (entries == EW'(POOL_DEPTH));
    old_bit   = |(hash_rd & buckets[BW-1:0]);
    gtarget   = old_bit ? hi : lo;
    new_node  = free_head[PW] ? fresh[PW-1:0] : free_head[PW-1:0];
    coll_inc  = (coll != u64ht_pkg::COLL_MAX) ? coll + 12'd1 : coll;
    // load the result register once the old word is gone or leaving, and no config write comes in
    res_load  = (state == B_RESP) && !cfg_we && (!res_valid || pop);
  end

  always_comb begin
    head_we    = 1'b0;
    head_waddr = cur_idx;
    head_wdata = NIL;
    head_raddr = cur_hidx;
    node_raddr = node;
    data_waddr = node;
    key_we     = 1'b0;
    val_we     = 1'b0;
    hash_we    = 1'b0;
    link_we    = 1'b0;
    link_waddr = node;
    link_wdata = free_head;
    q_pop      = 1'b0;
    unique case (state)
      B_CLEAR: begin
        head_we    = 1'b1;
        head_waddr = clr;
      end
      B_IDLE: begin
        head_raddr = q_idx;
        q_pop      = q_valid;
      end
      B_HEAD:   node_raddr = head_rd[PW-1:0];
      B_WALK: begin
        node_raddr = link_rd[PW-1:0];
        if (key_hit) begin
          if (cur.req == u64ht_pkg::REQ_PUT) begin
            val_we = 1'b1;
          end else if (cur.req == u64ht_pkg::REQ_REMOVE) begin
            // unlink: at the head, or after the previous node
            if (prev[PW]) begin
              head_we    = 1'b1;
              head_wdata = link_rd;
            end else begin
              link_we    = 1'b1;
              link_waddr = prev[PW-1:0];
              link_wdata = link_rd;
            end
          end
        end
      end
      B_REM:    link_we = 1'b1;
      B_INS:    node_raddr = free_head[PW-1:0];
      B_INS2: begin
        data_waddr = new_node;
        key_we     = 1'b1;
        val_we     = 1'b1;
        hash_we    = 1'b1;
        link_we    = 1'b1;
        link_waddr = new_node;
        link_wdata = head_rd;
        head_we    = 1'b1;
        head_wdata = LW'(new_node);
      end
      B_GHEAD:  head_raddr = gi;
      B_GHEADW: node_raddr = head_rd[PW-1:0];
      B_GNODE: begin
        node_raddr = link_rd[PW-1:0];
        link_we    = 1'b1;
        link_wdata = gtarget;
      end
      B_GWB: begin
        head_we    = 1'b1;
        head_waddr = gi;
        head_wdata = lo;
      end
      B_GWB2: begin
        head_we    = 1'b1;
        head_waddr = gi | buckets[BW-1:0];
        head_wdata = hi;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= B_CLEAR;
      clr       <= '0;
      buckets   <= start_buckets(u64ht_pkg::MIN_LOG2);
      entries   <= '0;
      coll      <= '0;
      fresh     <= '0;
      free_head <= NIL;
      res_valid <= 1'b0;
    end else begin
      if (res_load) begin
        res_valid <= 1'b1;
      end else if (pop && res_valid) begin
        res_valid <= 1'b0;
      end
      if (cfg_we) begin
        state     <= B_CLEAR;
        clr       <= '0;
        buckets   <= start_buckets(cfg_log2);
        entries   <= '0;
        coll      <= '0;
        fresh     <= '0;
        free_head <= NIL;
      end else begin
        unique case (state)
          B_CLEAR: begin
            clr <= clr + 1'b1;
            if (clr == BW'(MAX_BUCKETS - 1)) begin
              state <= B_IDLE;
            end
          end
          B_IDLE: begin
            if (q_valid) begin
              cur     <= q_item;
              cur_idx <= q_idx;
              state   <= B_HEAD;
            end
          end
          B_HEAD: begin
            prev <= NIL;
            rd   <= '0;
            st   <= u64ht_pkg::ST_OK;
            if (head_rd[PW]) begin
              state <= B_MISS;
            end else begin
              node  <= head_rd[PW-1:0];
              state <= B_WALK;
            end
          end
          B_WALK: begin
            if (key_hit) begin
              unique case (cur.req)
                u64ht_pkg::REQ_GET: begin
                  rd    <= val_rd;
                  state <= B_RESP;
                end
                u64ht_pkg::REQ_REMOVE: state <= B_REM;
                default:               state <= B_RESP;
              endcase
            end else if (link_rd[PW]) begin
              state <= B_MISS;
            end else begin
              prev <= LW'(node);
              node <= link_rd[PW-1:0];
            end
          end
          B_REM: begin
            free_head <= LW'(node);
            entries   <= entries - 1'b1;
            state     <= B_RESP;
          end
          B_MISS: begin
            unique case (cur.req)
              u64ht_pkg::REQ_PUT: begin
                if (grow_need) begin
                  gi    <= '0;
                  gcnt  <= '0;
                  state <= B_GHEAD;
                end else begin
                  state <= B_INS;
                end
              end
              u64ht_pkg::REQ_GET, u64ht_pkg::REQ_REMOVE: begin
                st    <= u64ht_pkg::ST_MISS;
                state <= B_RESP;
              end
              default: state <= B_RESP;
            endcase
          end
          B_INS: begin
            if (pool_full) begin
              st    <= u64ht_pkg::ST_FULL;
              state <= B_RESP;
            end else begin
              cur_idx <= cur_hidx;
              state   <= B_INS2;
            end
          end
          B_INS2: begin
            if (!head_rd[PW]) begin
              coll <= coll_inc;
            end
            if (free_head[PW]) begin
              fresh <= fresh + 1'b1;
            end else begin
              free_head <= link_rd;
            end
            entries <= entries + 1'b1;
            state   <= B_RESP;
          end
          B_GHEAD: begin
            lo    <= NIL;
            hi    <= NIL;
            state <= B_GHEADW;
          end
          B_GHEADW: begin
            if (head_rd[PW]) begin
              state <= B_GWB;
            end else begin
              node  <= head_rd[PW-1:0];
              state <= B_GNODE;
            end
          end
          B_GNODE: begin
            if (!gtarget[PW]) begin
              gcnt <= gcnt + 1'b1;
            end
            if (old_bit) begin
              hi <= LW'(node);
            end else begin
              lo <= LW'(node);
            end
            if (link_rd[PW]) begin
              state <= B_GWB;
            end else begin
              node <= link_rd[PW-1:0];
            end
          end
          B_GWB: state <= B_GWB2;
          B_GWB2: begin
            gi <= gi + 1'b1;
            if (gi == mask) begin
              buckets <= {buckets[NB-2:0], 1'b0};
              coll    <= (32'(gcnt) > 32'(u64ht_pkg::COLL_MAX)) ?
                         u64ht_pkg::COLL_MAX : u64ht_pkg::COLL_W'(gcnt);
              state   <= B_INS;
            end else begin
              state <= B_GHEAD;
            end
          end
          B_RESP: begin
            if (res_load) begin
              res_status  <= st;
              res_value   <= rd;
              res_entries <= u64ht_pkg::CNT_OUT_W'(entries);
              res_buckets <= u64ht_pkg::CNT_OUT_W'(buckets);
              res_coll    <= coll;
              state       <= B_IDLE;
            end
          end
          default: state <= B_IDLE;
        endcase
      end
    end
  end

  assign clearing = (state == B_CLEAR);

  u64ht_ram #(.WIDTH(LW), .DEPTH(MAX_BUCKETS)) u_head (
    .clk(clk), .we(head_we), .waddr(head_waddr), .wdata(head_wdata),
    .raddr(head_raddr), .rdata(head_rd)
  );

  u64ht_ram #(.WIDTH(64), .DEPTH(POOL_DEPTH)) u_key (
    .clk(clk), .we(key_we), .waddr(data_waddr), .wdata(cur.key),
    .raddr(node_raddr), .rdata(key_rd)
  );

  u64ht_ram #(.WIDTH(64), .DEPTH(POOL_DEPTH)) u_val (
    .clk(clk), .we(val_we), .waddr(data_waddr), .wdata(cur.value),
    .raddr(node_raddr), .rdata(val_rd)
  );

  u64ht_ram #(.WIDTH(BW), .DEPTH(POOL_DEPTH)) u_hash (
    .clk(clk), .we(hash_we), .waddr(data_waddr), .wdata(cur.hash[BW-1:0]),
    .raddr(node_raddr), .rdata(hash_rd)
  );

  u64ht_ram #(.WIDTH(LW), .DEPTH(POOL_DEPTH)) u_link (
    .clk(clk), .we(link_we), .waddr(link_waddr), .wdata(link_wdata),
    .raddr(node_raddr), .rdata(link_rd)
  );

endmodule

// ----- sv/u64ht_checker.sv -----
// Port-level checks for the hash table top, attached by bind.
// Depends on u64ht_pkg and u64_key_chained_hash_table_top.
module u64ht_checker (
  input logic        clk,
  input logic        rst,
  input logic        push,
  input logic        full,
  input logic [1:0]  req_type,
  input logic [63:0] key,
  input logic [63:0] value,
  input logic        empty,
  input logic        pop,
  input logic [1:0]  status,
  input logic [63:0] read_value,
  input logic [12:0] entry_count,
  input logic [12:0] bucket_total,
  input logic [11:0] collision_count,
  input logic        cfg_valid,
  input logic        cfg_ready,
  input logic [3:0]  initial_bucket_log2
);

  // only a successful request may carry a nonzero value
  a_value_zero: assert property (@(posedge clk) disable iff (rst)
    !empty && status != u64ht_pkg::ST_OK |-> read_value == 64'd0)
    else $error("nonzero read_value on failed request");

  // a waiting result holds until popped
  a_hold: assert property (@(posedge clk) disable iff (rst)
    !empty && !pop |=> !empty && $stable(status) && $stable(read_value)
      && $stable(entry_count))
    else $error("result changed while waiting");

  // a configuration write starts the clear sweep
  a_cfg_clear: assert property (@(posedge clk) disable iff (rst)
    cfg_valid && cfg_ready |=> full)
    else $error("input open right after configuration write");

  // bucket count never drops below the minimum
  a_min_buckets: assert property (@(posedge clk) disable iff (rst)
    !empty |-> bucket_total >= (13'd1 << u64ht_pkg::MIN_LOG2))
    else $error("bucket count below minimum");

endmodule

bind u64_key_chained_hash_table_top u64ht_checker u_checker (.*);
